// ===== rtl/core/sgf_pkg.sv =====
// sgf_pkg: payload structs, register map and divide-by-nine helper
// for the sobel gradient filter; no dependencies
`timescale 1ns / 1ps

package sgf_pkg;

    // register map, index = byte address / 4
    localparam logic REG_IMAGE_COLS = 1'b0;
    localparam logic REG_IMAGE_ROWS = 1'b1;

    localparam int          COLS_W     = 13;
    localparam int          ROWS_W     = 16;
    localparam logic [12:0] COLS_RESET = 13'd640;
    localparam logic [15:0] ROWS_RESET = 16'd480;
    localparam int          MIN_DIM    = 3;

    localparam int CENTER_ROW_W = 16;
    localparam int CENTER_COL_W = 12;

    // 3641 / 2^15 is just above 1/9, exact floor for magnitudes up to 1020
    localparam logic [11:0] DIV9_RECIP = 12'd3641;
    localparam int          DIV9_SHIFT = 15;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } pixel_t;

    typedef struct packed {
        logic [CENTER_ROW_W-1:0] center_row;
        logic [CENTER_COL_W-1:0] center_col;
        logic [7:0]              grad_x;
        logic [7:0]              grad_y;
        logic [7:0]              magnitude;
        logic                    frame_end;
    } result_t;

    // one column of the two stored lines
    typedef struct packed {
        logic [7:0] two_above;
        logic [7:0] one_above;
    } line_pair_t;

    // signed sum / 9, truncated toward zero, low 8 bits
    function automatic logic [7:0] div9_low8(input logic signed [10:0] s);
        logic [9:0]  mag;
        logic [21:0] prod;
        logic [7:0]  q;
        mag  = s[10] ? 10'(-s) : 10'(s);
        prod = 22'(mag) * 22'(DIV9_RECIP);
        q    = 8'(prod >> DIV9_SHIFT);
        return s[10] ? 8'(-q) : q;
    endfunction

endpackage

// ===== rtl/core/sgf_line_buffer.sv =====
// sgf_line_buffer: two stored image lines in one ram, registered read
// with same-cycle write bypass; uses sgf_pkg
`timescale 1ns / 1ps

module sgf_line_buffer #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  sgf_pkg::line_pair_t wr_data,
    output sgf_pkg::line_pair_t rd_data
);

    sgf_pkg::line_pair_t ram [DEPTH];
    sgf_pkg::line_pair_t ram_q_reg;
    sgf_pkg::line_pair_t byp_data_reg;
    logic                byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            ram_q_reg    <= ram[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // write and read on the same column in one cycle: take the new data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : ram_q_reg;

endmodule

// ===== rtl/core/sgf_gradient.sv =====
// sgf_gradient: 3x3 window columns and sobel x/y sums scaled by 1/9
// uses sgf_pkg
`timescale 1ns / 1ps

module sgf_gradient (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  logic [7:0] top_px,
    input  logic [7:0] mid_px,
    input  logic [7:0] bot_px,
    output logic [7:0] grad_x,
    output logic [7:0] grad_y
);

    // two older columns: [0..2] left, [3..5] middle, top to bottom
    logic [7:0] win_reg [6];

    logic [9:0]         sum_right;
    logic [9:0]         sum_left;
    logic [9:0]         sum_bottom;
    logic [9:0]         sum_top;
    logic signed [10:0] sx;
    logic signed [10:0] sy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= 8'd0;
            end
        end
        else if (shift_en)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_px;
            win_reg[4] <= mid_px;
            win_reg[5] <= bot_px;
        end
    end

    always_comb
    begin
        sum_right  = 10'(top_px) + {1'b0, mid_px, 1'b0} + 10'(bot_px);
        sum_left   = 10'(win_reg[0]) + {1'b0, win_reg[1], 1'b0} + 10'(win_reg[2]);
        sum_bottom = 10'(win_reg[2]) + {1'b0, win_reg[5], 1'b0} + 10'(bot_px);
        sum_top    = 10'(win_reg[0]) + {1'b0, win_reg[3], 1'b0} + 10'(top_px);
        sx         = signed'(11'(sum_right)) - signed'(11'(sum_left));
        sy         = signed'(11'(sum_bottom)) - signed'(11'(sum_top));
        grad_x     = sgf_pkg::div9_low8(sx);
        grad_y     = sgf_pkg::div9_low8(sy);
    end

endmodule

// ===== rtl/core/sobel_gradient_filter.sv =====
// sobel_gradient_filter: streaming 3x3 sobel gradient and magnitude
// depends on sgf_pkg, sgf_line_buffer, sgf_gradient
`timescale 1ns / 1ps

//  channel   direction  handshake                  payload
//  pixel     in         pixel_valid/pixel_ready    sgf_pkg::pixel_t
//  result    out        result_valid/result_ready  sgf_pkg::result_t
//  apb       in         psel/penable/pready        image_cols, image_rows
//
//  one pixel per clock sustained while results are accepted; the pixel that
//  completes a window yields a result via line ram read, gradient, magnitude
//  the single-port-write line ram and its registered read set the pipeline
//  reset clears counters, window and stage valids; the line ram is not cleared
//  a stall on the result side backs up stage by stage to pixel_ready
//  border positions produce no result transaction
module sobel_gradient_filter #(
    parameter int MAX_COLS = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    // pixel stream
    input  logic             pixel_valid,
    output logic             pixel_ready,
    input  sgf_pkg::pixel_t  pixel_data,
    // result stream
    output logic             result_valid,
    input  logic             result_ready,
    output sgf_pkg::result_t result_data,
    // configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int CMPW = (CW + 1 > sgf_pkg::COLS_W) ? CW + 1 : sgf_pkg::COLS_W;
    localparam int RW   = sgf_pkg::ROWS_W;

    // ---------------- configuration registers ----------------
    logic [sgf_pkg::COLS_W-1:0] image_cols_reg;
    logic [RW-1:0]              image_rows_reg;
    logic                       cfg_write;
    logic                       cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_cols_reg <= sgf_pkg::COLS_RESET;
            image_rows_reg <= sgf_pkg::ROWS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sgf_pkg::REG_IMAGE_COLS: image_cols_reg <= pwdata[sgf_pkg::COLS_W-1:0];
                sgf_pkg::REG_IMAGE_ROWS: image_rows_reg <= pwdata[RW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            sgf_pkg::REG_IMAGE_COLS: prdata = 32'(image_cols_reg);
            sgf_pkg::REG_IMAGE_ROWS: prdata = 32'(image_rows_reg);
            default:                 prdata = 32'd0;
        endcase
    end

    // bounds as used: columns clamped to [3, MAX_COLS], rows to at least 3
    logic [CMPW-1:0] cols_raw;
    logic [CMPW-1:0] eff_cols;
    logic [RW-1:0]   eff_rows;

    always_comb
    begin
        cols_raw = CMPW'(image_cols_reg);
        if (cols_raw < CMPW'(sgf_pkg::MIN_DIM))
        begin
            eff_cols = CMPW'(sgf_pkg::MIN_DIM);
        end
        else if (cols_raw > CMPW'(MAX_COLS))
        begin
            eff_cols = CMPW'(MAX_COLS);
        end
        else
        begin
            eff_cols = cols_raw;
        end
        eff_rows = (image_rows_reg < RW'(sgf_pkg::MIN_DIM)) ? RW'(sgf_pkg::MIN_DIM)
                                                             : image_rows_reg;
    end

    // ---------------- pipeline handshake ----------------
    logic s1_valid_reg;
    logic s1_emit_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic pixel_fire;
    logic s1_go;
    logic s2_go;
    logic s2_free;

    assign s2_go       = s2_valid_reg && (!out_valid_reg || result_ready);
    assign s2_free     = !s2_valid_reg || s2_go;
    // a border pixel leaves stage 1 without needing stage 2
    assign s1_go       = s1_valid_reg && (!s1_emit_reg || s2_free);
    assign pixel_ready = !s1_valid_reg || s1_go;
    assign pixel_fire  = pixel_valid && pixel_ready;

    // ---------------- position counters ----------------
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_cur;
    logic [RW-1:0] row_cur;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_next;
    logic          emit_cur;
    logic          end_cur;

    always_comb
    begin
        col_cur  = pixel_data.frame_start ? '0 : col_reg;
        row_cur  = pixel_data.frame_start ? '0 : row_reg;
        col_next = col_cur + CW'(1);
        row_next = row_cur;
        // counters past a shrunken bound also wrap here
        if (CMPW'(col_cur) + CMPW'(1) >= eff_cols)
        begin
            col_next = '0;
            row_next = ((RW + 1)'(row_cur) + (RW + 1)'(1) >= (RW + 1)'(eff_rows))
                       ? '0 : row_cur + RW'(1);
        end
        emit_cur = (row_cur >= RW'(2)) && (CMPW'(col_cur) >= CMPW'(2))
                && (row_cur < eff_rows) && (CMPW'(col_cur) < eff_cols);
        end_cur  = (row_cur == eff_rows - RW'(1))
                && (CMPW'(col_cur) == eff_cols - CMPW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pixel_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage 1: line ram read, window ----------------
    logic [7:0]          s1_pixel_reg;
    logic [CW-1:0]       s1_col_reg;
    logic [RW-1:0]       s1_row_reg;
    logic                s1_end_reg;
    sgf_pkg::line_pair_t lb_rd;
    sgf_pkg::line_pair_t lb_wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else if (pixel_fire)
        begin
            s1_valid_reg <= 1'b1;
            s1_emit_reg  <= emit_cur;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_fire)
        begin
            s1_pixel_reg <= pixel_data.pixel;
            s1_col_reg   <= col_cur;
            s1_row_reg   <= row_cur;
            s1_end_reg   <= end_cur;
        end
    end

    // column shifts down: one-above moves to two-above, new pixel to one-above
    assign lb_wr.two_above = lb_rd.one_above;
    assign lb_wr.one_above = s1_pixel_reg;

    sgf_line_buffer #(
        .DEPTH (MAX_COLS),
        .AW    (CW)
    ) u_line_buffer (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (pixel_fire),
        .rd_addr (col_cur),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (lb_wr),
        .rd_data (lb_rd)
    );

    logic [7:0] grad_x_s1;
    logic [7:0] grad_y_s1;

    sgf_gradient u_gradient (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_go),
        .top_px   (lb_rd.two_above),
        .mid_px   (lb_rd.one_above),
        .bot_px   (s1_pixel_reg),
        .grad_x   (grad_x_s1),
        .grad_y   (grad_y_s1)
    );

    // ---------------- stage 2: gradients registered ----------------
    logic [7:0]                      s2_gx_reg;
    logic [7:0]                      s2_gy_reg;
    logic [sgf_pkg::CENTER_ROW_W-1:0] s2_row_reg;
    logic [sgf_pkg::CENTER_COL_W-1:0] s2_col_reg;
    logic                            s2_end_reg;

    // a border pixel passing stage 1 leaves a waiting stage 2 untouched
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_emit_reg)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_go)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit_reg)
        begin
            s2_gx_reg  <= grad_x_s1;
            s2_gy_reg  <= grad_y_s1;
            s2_row_reg <= s1_row_reg - RW'(1);
            s2_col_reg <= sgf_pkg::CENTER_COL_W'(CMPW'(s1_col_reg) - CMPW'(1));
            s2_end_reg <= s1_end_reg;
        end
    end

    // ---------------- output register: magnitude ----------------
    logic [15:0]      mag_sum;
    sgf_pkg::result_t out_reg;

    assign mag_sum = 16'(s2_gx_reg) * 16'(s2_gx_reg) + 16'(s2_gy_reg) * 16'(s2_gy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            out_reg.center_row <= s2_row_reg;
            out_reg.center_col <= s2_col_reg;
            out_reg.grad_x     <= s2_gx_reg;
            out_reg.grad_y     <= s2_gy_reg;
            out_reg.magnitude  <= mag_sum[7:0];
            out_reg.frame_end  <= s2_end_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    // ---------------- assertions ----------------
    // results only ever name interior centers
    a_interior_center: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.center_row != '0) && (out_reg.center_col != '0))
        else $error("result for a border position");

    // an accepted pixel always lands in stage 1
    a_s1_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_fire |=> s1_valid_reg)
        else $error("accepted pixel lost before stage 1");

    // a blocked stage 1 keeps its position
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> s1_valid_reg && $stable(s1_col_reg)
                                     && $stable(s1_pixel_reg))
        else $error("stage 1 changed while blocked");

    // a blocked stage 2 keeps its gradients
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_go) |=> s2_valid_reg && $stable(s2_gx_reg)
                                     && $stable(s2_gy_reg))
        else $error("stage 2 changed while blocked");

endmodule
